[design/ebni_pkg.sv]
package ebni_pkg;

    // widths fixed by the item fields and registers
    localparam int unsigned GROUP_W   = 2;
    localparam int unsigned ENTITY_W  = 4;
    localparam int unsigned NODE_W    = 9;
    localparam int unsigned POINT_W   = 6;
    localparam int unsigned ORDER_W   = 3;
    localparam int unsigned DIM_W     = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 3;

    localparam int unsigned MAX_ORDER_DEF = 7;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 1'b1;
    localparam logic [DIM_W-1:0]     DIM_RESET     = 2'd2;
    localparam logic [ORDER_W-1:0]   ORDER_RESET   = 3'd1;

    // sequencer step codes
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    // jump condition codes
    localparam logic C_START = 1'b0;
    localparam logic C_LAST  = 1'b1;

    typedef logic [NODE_W-1:0] t_node;

    // one control word of the microprogram
    typedef struct packed {
        logic load;   // take a request and set up the datapath
        logic emit;   // put a point on the result ports
        logic adv;    // step the point counters
        logic cond;   // jump condition code
        logic tgt;    // next step when the condition holds
        logic alt;    // next step otherwise
    } t_ctrl;

    // program store
    function automatic t_ctrl ucode(input logic step);
        t_ctrl cw;
        unique case (step)
            S_IDLE: cw = '{load: 1'b1, emit: 1'b0, adv: 1'b0,
                           cond: C_START, tgt: S_EMIT, alt: S_IDLE};
            S_EMIT: cw = '{load: 1'b0, emit: 1'b1, adv: 1'b1,
                           cond: C_LAST, tgt: S_IDLE, alt: S_EMIT};
            default: cw = '0;
        endcase
        return cw;
    endfunction

    // entities in each group, by dimension
    function automatic logic [ENTITY_W-1:0] group_size(input logic [DIM_W-1:0] d,
                                                       input logic [GROUP_W-1:0] g);
        logic [ENTITY_W-1:0] s;
        s = '0;
        case (d)
            2'd1: if (g == 2'd0) s = 4'd2;
            2'd2: if (g == 2'd0 || g == 2'd1) s = 4'd4;
            2'd3: begin
                case (g)
                    2'd0:    s = 4'd6;
                    2'd1:    s = 4'd12;
                    2'd2:    s = 4'd8;
                    default: s = '0;
                endcase
            end
            default: s = '0;
        endcase
        return s;
    endfunction

    // strides and end offsets per order: (n+1)^2, n*(n+1), n*(n+1)^2
    function automatic t_node sq_tab(input logic [ORDER_W-1:0] n);
        logic [3:0] p;
        p = {1'b0, n} + 4'd1;
        return t_node'(p) * t_node'(p);
    endfunction

    function automatic t_node np_tab(input logic [ORDER_W-1:0] n);
        logic [3:0] p;
        p = {1'b0, n} + 4'd1;
        return t_node'(n) * t_node'(p);
    endfunction

    function automatic t_node npp_tab(input logic [ORDER_W-1:0] n);
        t_node t;
        case (n)
            3'd0:    t = 9'd0;
            3'd1:    t = 9'd4;
            3'd2:    t = 9'd18;
            3'd3:    t = 9'd48;
            3'd4:    t = 9'd100;
            3'd5:    t = 9'd180;
            3'd6:    t = 9'd294;
            default: t = 9'd448;
        endcase
        return t;
    endfunction

endpackage

[design/element_boundary_node_indexer.sv]
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+--------------------------------------
// request   | in        | start, busy          | i_group, i_entity
// result    | out       | o_valid strobe       | o_node_index, o_point_number,
//           |           |                      | o_last_point, o_bad_request
// config    | in        | i_cfg_valid/ready    | i_cfg_index, i_cfg_data
//
// A request is loaded by the idle step, then the emit step of the microprogram gives
// one result per cycle, count results in all, count being 1, order+1 or (order+1)^2
// (up to 64). A bad request gives one result. Results are registered, appear in the
// cycle after the emit step and last one cycle; the receiver cannot stall them.
// Reset (synchronous, active low) returns the sequencer to idle and loads
// dimension 2 and order 1.
module element_boundary_node_indexer
    import ebni_pkg::*;
#(
    parameter int unsigned MAX_ORDER = ebni_pkg::MAX_ORDER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ebni_pkg::GROUP_W-1:0]      i_group,
    input  logic [ebni_pkg::ENTITY_W-1:0]     i_entity,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ebni_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ebni_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output logic                              o_valid,
    output logic [ebni_pkg::NODE_W-1:0]       o_node_index,
    output logic [ebni_pkg::POINT_W-1:0]      o_point_number,
    output logic                              o_last_point,
    output logic                              o_bad_request
);

    localparam logic [ORDER_W-1:0] MaxN = ORDER_W'(MAX_ORDER);

    logic               r_step, n_step;
    logic [DIM_W-1:0]   r_dim;
    logic [ORDER_W-1:0] r_order;
    t_ctrl              cw;
    logic               cond_ok, last;

    // datapath registers
    t_node              r_addr, r_row, r_s0, r_s1;
    logic [ORDER_W-1:0] r_i, r_j, r_lim_i, r_lim_j;
    logic [POINT_W-1:0] r_pt;
    logic               r_bad;

    // output registers
    logic               r_o_valid, r_o_last, r_o_bad;
    t_node              r_o_node;
    logic [POINT_W-1:0] r_o_pt;

    // request decode
    logic [ORDER_W-1:0] n;
    t_node              st  [3];
    t_node              nst [3];
    logic               good;
    logic [1:0]         nfree;
    logic [1:0]         fa, lo, hi;
    t_node              base, s0, s1;
    logic [ORDER_W-1:0] lim_i, lim_j;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= DIM_RESET;
            r_order <= ORDER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIMENSION: r_dim   <= i_cfg_data[DIM_W-1:0];
                CFG_ORDER:     r_order <= i_cfg_data[ORDER_W-1:0];
                default:       ;
            endcase
        end
    end

    // clamp order and build strides
    always_comb begin
        n = r_order;
        if (n == '0) n = ORDER_W'(1);
        if (n > MaxN) n = MaxN;
        st[0]  = t_node'(1);
        st[1]  = t_node'(n) + t_node'(1);
        st[2]  = sq_tab(n);
        nst[0] = t_node'(n);
        nst[1] = np_tab(n);
        nst[2] = npp_tab(n);
    end

    // decode group and entity into base address, strides and loop limits
    always_comb begin
        good  = (r_dim != 2'd0) && ({1'b0, i_group} < {1'b0, r_dim}) &&
                (i_entity < group_size(r_dim, i_group));
        nfree = r_dim - 2'd1 - i_group;
        fa    = '0;
        lo    = '0;
        hi    = '0;
        base  = '0;
        s0    = '0;
        s1    = '0;
        if (nfree == 2'd0) begin
            // corner
            for (int a = 0; a < 3; a++) begin
                if (i_entity[a] && (a < int'(r_dim))) base = base + nst[a];
            end
        end else if (r_dim == 2'd3 && i_group == 2'd1) begin
            // edge of a hexahedron
            fa = i_entity[3:2];
            lo = (fa == 2'd0) ? 2'd1 : 2'd0;
            hi = (fa == 2'd2) ? 2'd1 : 2'd2;
            base = (i_entity[0] ? nst[lo] : '0) + (i_entity[1] ? nst[hi] : '0);
            s0 = st[fa];
        end else begin
            // face, or edge of a quadrilateral
            fa = i_entity[2:1];
            lo = (fa == 2'd0) ? 2'd1 : 2'd0;
            hi = (fa == 2'd2) ? 2'd1 : 2'd2;
            base = i_entity[0] ? nst[fa] : '0;
            s0 = st[lo];
            s1 = st[hi];
        end
        lim_i = (nfree != 2'd0) ? n : '0;
        lim_j = (nfree == 2'd2) ? n : '0;
        if (!good) begin
            base  = '0;
            lim_i = '0;
            lim_j = '0;
        end
    end

    // sequencer
    assign cw      = ucode(r_step);
    assign last    = (r_i == r_lim_i) && (r_j == r_lim_j);
    assign cond_ok = (cw.cond == C_START) ? start : last;
    assign n_step  = cond_ok ? cw.tgt : cw.alt;
    assign busy    = (r_step != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // point counters and address accumulators
    always_ff @(posedge i_clk) begin
        if (cw.load && start) begin
            r_addr  <= base;
            r_row   <= base;
            r_s0    <= s0;
            r_s1    <= s1;
            r_i     <= '0;
            r_j     <= '0;
            r_lim_i <= lim_i;
            r_lim_j <= lim_j;
            r_pt    <= '0;
            r_bad   <= !good;
        end else if (cw.adv && !last) begin
            r_pt <= r_pt + POINT_W'(1);
            if (r_i != r_lim_i) begin
                r_i    <= r_i + ORDER_W'(1);
                r_addr <= r_addr + r_s0;
            end else begin
                r_i    <= '0;
                r_j    <= r_j + ORDER_W'(1);
                r_row  <= r_row + r_s1;
                r_addr <= r_row + r_s1;
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= cw.emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (cw.emit) begin
            r_o_node <= r_addr;
            r_o_pt   <= r_pt;
            r_o_last <= last;
            r_o_bad  <= r_bad;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_node_index   = r_o_node;
    assign o_point_number = r_o_pt;
    assign o_last_point   = r_o_last;
    assign o_bad_request  = r_o_bad;

endmodule

[bench/element_boundary_node_indexer_tb.sv]
module element_boundary_node_indexer_tb;
    import ebni_pkg::*;

    // boundary groups, highest entity kind first
    localparam logic [GROUP_W-1:0] GRP_HIGH = 2'd0;
    localparam logic [GROUP_W-1:0] GRP_MID  = 2'd1;
    localparam logic [GROUP_W-1:0] GRP_LOW  = 2'd2;
    localparam logic [GROUP_W-1:0] GRP_NONE = 2'd3;

    localparam int unsigned TOP_ORDER   = MAX_ORDER_DEF;
    localparam int unsigned RESET_HOLD  = 11;
    localparam int unsigned SETTLE      = 70;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned IDLE_PCT    = 21;
    localparam int unsigned NUM_PHASES  = 9;
    localparam int unsigned PHASE_ITEMS = 12;

    typedef struct {
        logic [NODE_W-1:0]  node;
        logic [POINT_W-1:0] point;
        logic               last;
        logic               bad;
    } t_boundary_point;

    typedef struct {
        logic [DIM_W-1:0]    dim;
        logic [ORDER_W-1:0]  order;
        logic [GROUP_W-1:0]  group;
        logic [ENTITY_W-1:0] entity;
        logic                typed;
        logic [NODE_W-1:0]   node;
        logic                bad;
    } t_request_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [GROUP_W-1:0]    i_group;
    logic [ENTITY_W-1:0]   i_entity;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;
    logic                  o_valid;
    logic [NODE_W-1:0]     o_node_index;
    logic [POINT_W-1:0]    o_point_number;
    logic                  o_last_point;
    logic                  o_bad_request;

    // local copy of the registers
    logic [DIM_W-1:0]      dim_reg;
    logic [ORDER_W-1:0]    order_reg;

    t_boundary_point       pending_points[$];
    int unsigned           errors = 0;
    int unsigned           cycle_count = 0;
    bit                    idle_on;

    element_boundary_node_indexer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_group        (i_group),
        .i_entity       (i_entity),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_node_index   (o_node_index),
        .o_point_number (o_point_number),
        .o_last_point   (o_last_point),
        .o_bad_request  (o_bad_request)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // compare each result with the oldest expected point
    always @(posedge i_clk) begin
        t_boundary_point want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result: node_index %0d point_number %0d",
                       o_node_index, o_point_number);
                errors++;
            end else begin
                want = pending_points.pop_front();
                if (o_node_index !== want.node) begin
                    $error("node_index: expected %0d, got %0d", want.node, o_node_index);
                    errors++;
                end
                if (o_point_number !== want.point) begin
                    $error("point_number: expected %0d, got %0d", want.point,
                           o_point_number);
                    errors++;
                end
                if (o_last_point !== want.last) begin
                    $error("last_point: expected %0d, got %0d", want.last, o_last_point);
                    errors++;
                end
                if (o_bad_request !== want.bad) begin
                    $error("bad_request: expected %0d, got %0d", want.bad, o_bad_request);
                    errors++;
                end
            end
        end
    end

    // faces, edges or corners in a group for a given dimension
    function automatic int unsigned entities_in_group(input int unsigned d,
                                                      input int unsigned g);
        int unsigned n;
        n = 0;
        case (d)
            1: if (g == GRP_HIGH) n = 2;
            2: if (g == GRP_HIGH || g == GRP_MID) n = 4;
            3: begin
                if (g == GRP_HIGH) n = 6;
                else if (g == GRP_MID) n = 12;
                else if (g == GRP_LOW) n = 8;
            end
            default: n = 0;
        endcase
        return n;
    endfunction

    function automatic t_boundary_point make_point(input int unsigned node,
                                                   input int unsigned point,
                                                   input logic last, input logic bad);
        t_boundary_point pt;
        pt.node  = NODE_W'(node);
        pt.point = POINT_W'(point);
        pt.last  = last;
        pt.bad   = bad;
        return pt;
    endfunction

    // expected node addresses of one boundary entity, in emission order
    task automatic predict_boundary_nodes(input logic [GROUP_W-1:0] g,
                                          input logic [ENTITY_W-1:0] e);
        int unsigned d, n, p, nfree, count, fixed_axis, fixed_bit, m, a, idx;
        int unsigned c[3];
        int unsigned fr[2];
        d = dim_reg;
        n = order_reg;
        if (n < 1) n = 1;
        if (n > TOP_ORDER) n = TOP_ORDER;
        p = n + 1;
        c = '{0, 0, 0};
        fr = '{0, 0};
        if (d < 1 || g >= d || e >= entities_in_group(d, g)) begin
            pending_points.push_back(make_point(0, 0, 1'b1, 1'b1));
            return;
        end
        nfree = d - 1 - g;
        if (nfree == 0) begin
            // corner: each entity bit puts one axis at the far end
            for (a = 0; a < d; a++)
                c[a] = e[a] ? n : 0;
        end else if (d == 3 && g == GRP_MID) begin
            // edge in 3d runs along axis e/4, low bits place the other two
            fr[0] = e >> 2;
            fixed_bit = 0;
            for (a = 0; a < 3; a++) begin
                if (a != fr[0]) begin
                    c[a] = e[fixed_bit] ? n : 0;
                    fixed_bit++;
                end
            end
        end else begin
            // face in 3d or edge in 2d: axis e/2 pinned at 0 or n
            fixed_axis = e >> 1;
            c[fixed_axis] = e[0] ? n : 0;
            m = 0;
            for (a = 0; a < d; a++) begin
                if (a != fixed_axis && m < 2) begin
                    fr[m] = a;
                    m++;
                end
            end
        end
        count = (nfree == 0) ? 1 : (nfree == 1) ? p : p * p;
        for (idx = 0; idx < count; idx++) begin
            if (nfree >= 1) c[fr[0]] = idx % p;
            if (nfree == 2) c[fr[1]] = idx / p;
            pending_points.push_back(make_point(c[0] + c[1] * p + c[2] * p * p, idx,
                                                idx + 1 == count, 1'b0));
        end
    endtask

    // hand one item to the block, with random gaps in front of it
    task automatic send_request(input logic [GROUP_W-1:0] g,
                                input logic [ENTITY_W-1:0] e);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_group  <= g;
        i_entity <= e;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // hold off until every expected point has come and the block is idle
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_points.size() != 0 || busy !== 1'b0);
    endtask

    // write dimension then order, valid held high across both
    task automatic program_regs(input logic [CFG_DAT_W-1:0] dim_data,
                                input logic [CFG_DAT_W-1:0] order_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DIMENSION;
        i_cfg_data  <= dim_data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        dim_reg = dim_data[DIM_W-1:0];
        i_cfg_index <= CFG_ORDER;
        i_cfg_data  <= order_data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        order_reg = order_data;
        i_cfg_valid <= 1'b0;
    endtask

    t_request_row directed_rows[] = '{
        // reset setting: 2d, order 1
        '{2'd2, 3'd1, GRP_HIGH, 4'd0,  1'b0, 9'd0,   1'b0},
        '{2'd2, 3'd1, GRP_MID,  4'd3,  1'b1, 9'd3,   1'b0},
        '{2'd2, 3'd1, GRP_LOW,  4'd0,  1'b1, 9'd0,   1'b1},
        '{2'd2, 3'd1, GRP_HIGH, 4'd4,  1'b1, 9'd0,   1'b1},
        '{2'd2, 3'd1, GRP_MID,  4'd15, 1'b1, 9'd0,   1'b1},
        // largest element: 3d, order 7
        '{2'd3, 3'd7, GRP_HIGH, 4'd0,  1'b0, 9'd0,   1'b0},
        '{2'd3, 3'd7, GRP_HIGH, 4'd5,  1'b0, 9'd0,   1'b0},
        '{2'd3, 3'd7, GRP_MID,  4'd0,  1'b0, 9'd0,   1'b0},
        '{2'd3, 3'd7, GRP_MID,  4'd11, 1'b0, 9'd0,   1'b0},
        '{2'd3, 3'd7, GRP_LOW,  4'd0,  1'b1, 9'd0,   1'b0},
        '{2'd3, 3'd7, GRP_LOW,  4'd7,  1'b1, 9'd511, 1'b0},
        '{2'd3, 3'd7, GRP_HIGH, 4'd6,  1'b1, 9'd0,   1'b1},
        '{2'd3, 3'd7, GRP_MID,  4'd12, 1'b1, 9'd0,   1'b1},
        '{2'd3, 3'd7, GRP_NONE, 4'd0,  1'b1, 9'd0,   1'b1},
        // 1d corners
        '{2'd1, 3'd7, GRP_HIGH, 4'd1,  1'b1, 9'd7,   1'b0},
        '{2'd1, 3'd7, GRP_HIGH, 4'd0,  1'b1, 9'd0,   1'b0},
        '{2'd1, 3'd7, GRP_MID,  4'd0,  1'b1, 9'd0,   1'b1},
        // dimension zero rejects everything
        '{2'd0, 3'd1, GRP_HIGH, 4'd0,  1'b1, 9'd0,   1'b1},
        // order zero behaves as order one
        '{2'd2, 3'd0, GRP_HIGH, 4'd3,  1'b0, 9'd0,   1'b0},
        '{2'd2, 3'd0, GRP_MID,  4'd1,  1'b1, 9'd1,   1'b0},
        '{2'd3, 3'd1, GRP_MID,  4'd5,  1'b0, 9'd0,   1'b0}
    };

    logic [DIM_W-1:0]   phase_dim[NUM_PHASES]   = '{2'd3, 2'd1, 2'd2, 2'd3, 2'd0,
                                                    2'd3, 2'd2, 2'd1, 2'd3};
    logic [ORDER_W-1:0] phase_order[NUM_PHASES] = '{3'd7, 3'd1, 3'd7, 3'd1, 3'd5,
                                                    3'd0, 3'd3, 3'd6, 3'd3};

    initial begin
        logic [GROUP_W-1:0]  g;
        logic [ENTITY_W-1:0] e;
        int unsigned         d, size;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_group     <= '0;
        i_entity    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_DIMENSION;
        i_cfg_data  <= '0;
        dim_reg     = DIM_RESET;
        order_reg   = ORDER_RESET;
        idle_on     = 1'b1;
        repeat (RESET_HOLD) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].dim != dim_reg || directed_rows[r].order != order_reg) begin
                wait_for_results();
                program_regs({1'b0, directed_rows[r].dim}, directed_rows[r].order);
            end
            send_request(directed_rows[r].group, directed_rows[r].entity);
            if (directed_rows[r].typed)
                pending_points.push_back(make_point(directed_rows[r].node, 0, 1'b1,
                                                    directed_rows[r].bad));
            else
                predict_boundary_nodes(directed_rows[r].group, directed_rows[r].entity);
        end

        // random phases, one setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_results();
            program_regs({1'($urandom_range(0, 1)), phase_dim[ph]}, phase_order[ph]);
            idle_on = (ph != 2);
            d = dim_reg;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // pause mid-phase until the block has drained
                if (ph == 4 && k == PHASE_ITEMS / 2)
                    wait_for_results();
                if (d >= 1 && $urandom_range(0, 99) < 80) begin
                    g = GROUP_W'($urandom_range(0, d - 1));
                    size = entities_in_group(d, g);
                    e = ENTITY_W'($urandom_range(0, size - 1));
                end else begin
                    g = GROUP_W'($urandom_range(0, 3));
                    e = ENTITY_W'($urandom_range(0, 15));
                end
                send_request(g, e);
                predict_boundary_nodes(g, e);
            end
        end

        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
